// ===== rtl/olst_pkg.sv =====
`default_nettype none

package olst_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_FIND   = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_ROTATE = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/ordered_list_store_core.sv =====
// ordered_list_store_core: bounded ordered list of signed values, input positions from 1.
// Input channel (in_valid/in_stall): cmd, position, value_in. A transaction is
// taken when in_valid is high and in_stall is low. Output channel
// (out_valid/out_stall): status, value_out, position_out, entry_count, one
// result per command, in command order.
// Entries sit in a row of CAPACITY cells. Append, insert and delete update the row
// directly (each cell loads, takes its left or its right neighbor, or holds), so
// their result is valid the cycle after acceptance, as are all errors but a find miss.
// Find and read rotate the whole row by one cell per cycle, once round all CAPACITY
// cells, and inspect the head cell; the result is loaded from S_DONE once the output
// is free, and the row ends back in its original order.
// Throughput: one command per cycle for append, insert, delete and errors while
// out_stall is low; a find or read blocks new commands until its result is loaded.
// One command is in progress at a time; in_stall stays high during a scan and
// while a finished result is held by out_stall. A stalled result holds its
// value. Synchronous reset empties the list and drops any pending result;
// no clearing pass is needed, entry contents stay undefined until written.
`default_nettype none

module ordered_list_store_core
  import olst_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [POS_W-1:0]    position,
  input  wire logic [DATA_W-1:0]   value_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STAT_W-1:0]   status,
  output logic      [DATA_W-1:0]   value_out,
  output logic      [POS_W-1:0]    position_out,
  output logic      [POS_W-1:0]    entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(CAPACITY);
  localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int VW = VALUE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t        state;
  logic [CW-1:0] len;
  logic [KW-1:0] k;
  logic          scan_read;
  logic          found;
  logic [VW-1:0] key;
  logic [MW-1:0] target;
  logic [VW-1:0] prev;
  logic [VW-1:0] res_val;
  logic [KW-1:0] res_pos;

  logic [VW-1:0] vals [CAPACITY];

  logic          accept;
  logic          out_free;
  cell_op_t      cell_op;
  logic [MW-1:0] mark;
  logic [CW-1:0] len_next;
  logic          imm_load;
  logic [STAT_W-1:0] imm_status;
  logic          start_scan;
  logic          start_read;
  logic          full;
  logic          pos_ok;
  logic [MW-1:0] pos_x;
  logic [MW-1:0] len_x;
  logic [MW-1:0] k_x;
  logic [63:0]   vin_ext;
  logic [VW-1:0] key_in;
  logic [VW-1:0] head;
  logic          last_step;
  logic [63:0]   res_ext;
  logic [MW-1:0] res_pos_x;
  logic [MW-1:0] len_next_x;
  logic [MW-1:0] len_cur_x;
  logic          scan_ok;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;

  assign pos_x      = MW'(position);
  assign len_x      = MW'(len);
  assign k_x        = MW'(k);
  assign full       = (len == CW'(CAPACITY));
  assign pos_ok     = (pos_x != '0) && (pos_x <= len_x);
  assign vin_ext    = {{32{value_in[DATA_W-1]}}, value_in};
  assign key_in     = vin_ext[VW-1:0];
  assign head       = vals[0];
  assign last_step  = (k == KW'(CAPACITY - 1));
  assign res_ext    = 64'(res_val);
  assign res_pos_x  = MW'(res_pos);
  assign len_next_x = MW'(len_next);
  assign len_cur_x  = MW'(len);
  assign scan_ok    = scan_read || found;

  always_comb begin
    cell_op    = OP_HOLD;
    mark       = '0;
    len_next   = len;
    imm_load   = 1'b0;
    imm_status = ST_OK;
    start_scan = 1'b0;
    start_read = 1'b0;
    if (state == S_SCAN) cell_op = OP_ROTATE;
    if (accept) begin
      imm_load = 1'b1;
      case (cmd)
        CMD_APPEND: begin
          if (full) begin
            imm_status = ST_FULL;
          end else begin
            cell_op  = OP_APPEND;
            mark     = len_x;
            len_next = CW'(len + 1'b1);
          end
        end
        CMD_FIND: begin
          imm_load   = 1'b0;
          start_scan = 1'b1;
        end
        CMD_INSERT: begin
          if (full) begin
            imm_status = ST_FULL;
          end else if (!pos_ok) begin
            imm_status = ST_MISS;
          end else begin
            cell_op  = OP_INSERT;
            mark     = pos_x;
            len_next = CW'(len + 1'b1);
          end
        end
        CMD_DELETE: begin
          if (!pos_ok) begin
            imm_status = ST_MISS;
          end else begin
            cell_op  = OP_DELETE;
            mark     = MW'(pos_x - 1'b1);
            len_next = CW'(len - 1'b1);
          end
        end
        CMD_READ: begin
          if (!pos_ok) begin
            imm_status = ST_MISS;
          end else begin
            imm_load   = 1'b0;
            start_scan = 1'b1;
            start_read = 1'b1;
          end
        end
        default: imm_status = ST_MISS;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olst_cell #(
      .INDEX (i),
      .VW    (VW),
      .MW    (MW)
    ) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .mark  (mark),
      .din   (key_in),
      .left  (vals[(i + CAPACITY - 1) % CAPACITY]),
      .right (vals[(i + 1) % CAPACITY]),
      .q     (vals[i])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      k     <= '0;
      found <= 1'b0;
    end else begin
      len <= len_next;
      case (state)
        S_IDLE: begin
          if (start_scan) begin
            state <= S_SCAN;
            k     <= '0;
            found <= 1'b0;
          end
        end
        S_SCAN: begin
          k <= KW'(k + 1'b1);
          if (!scan_read && !found && (k_x < len_x) && (head == key)) found <= 1'b1;
          if (last_step) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    if (start_scan) begin
      scan_read <= start_read;
      key       <= key_in;
      target    <= MW'(pos_x - 1'b1);
    end
    if (state == S_SCAN) begin
      prev <= head;
      if (scan_read) begin
        if (k_x == target) res_val <= head;
      end else if (!found && (k_x < len_x) && (head == key)) begin
        res_pos <= k;
        res_val <= (k == '0) ? '0 : prev;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (imm_load || (state == S_DONE && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm_load) begin
      status       <= imm_status;
      value_out    <= '0;
      position_out <= '0;
      entry_count  <= len_next_x[POS_W-1:0];
    end else if (state == S_DONE && out_free) begin
      status       <= scan_ok ? ST_OK : ST_MISS;
      value_out    <= scan_ok ? res_ext[DATA_W-1:0] : '0;
      position_out <= (!scan_read && found) ? res_pos_x[POS_W-1:0] : '0;
      entry_count  <= len_cur_x[POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/olst_cell.sv =====
`default_nettype none

module olst_cell
  import olst_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int VW    = 32,
  parameter int MW    = 8
) (
  input  wire logic          clk,
  input  wire cell_op_t      op,
  input  wire logic [MW-1:0] mark,
  input  wire logic [VW-1:0] din,
  input  wire logic [VW-1:0] left,
  input  wire logic [VW-1:0] right,
  output logic      [VW-1:0] q
);

  localparam logic [MW-1:0] IDX = MW'(INDEX);

  logic [VW-1:0] q_next;

  always_comb begin
    q_next = q;
    case (op)
      OP_ROTATE: q_next = right;
      OP_APPEND: begin
        if (IDX == mark) q_next = din;
      end
      OP_INSERT: begin
        if (IDX == mark) q_next = din;
        else if (IDX > mark) q_next = left;
      end
      OP_DELETE: begin
        if (IDX >= mark) q_next = right;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

// ===== rtl/olst_checker.sv =====
`default_nettype none

module olst_checker
  import olst_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [CMD_W-1:0]  cmd,
  input wire logic [POS_W-1:0]  position,
  input wire logic [DATA_W-1:0] value_in,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [STAT_W-1:0] status,
  input wire logic [DATA_W-1:0] value_out,
  input wire logic [POS_W-1:0]  position_out,
  input wire logic [POS_W-1:0]  entry_count
);

  logic unused_in;
  assign unused_in = ^{in_valid, in_stall, cmd, position, value_in};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
      && $stable(position_out) && $stable(entry_count))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
    else $error("unknown status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value_out == '0 && position_out == '0)
    else $error("error result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(entry_count) <= CAPACITY)
    else $error("entry count beyond capacity");

endmodule

bind ordered_list_store_core olst_checker #(.CAPACITY(CAPACITY)) u_olst_checker (.*);

`default_nettype wire

// ===== tb/ordered_list_store_core_tb.sv =====
`timescale 1ns / 1ps

module ordered_list_store_core_tb;
  import olst_pkg::*;

  localparam int LIST_CAP       = 64;
  localparam int RANDOM_ITEMS   = 1775;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_DIRECTED     = 25;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  count;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              fixed;
    list_result_t      want;
  } list_cmd_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // after reset, extremes and error codes are typed in; the rest use the predictor
  localparam list_cmd_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{CMD_READ,    7'd1,   32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd0}},
    '{CMD_FIND,    7'd0,   32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd0}},
    '{CMD_DELETE,  7'd1,   32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd0}},
    '{CMD_INSERT,  7'd1,   32'h0000_0001, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd0}},
    '{CMD_APPEND,  7'd0,   32'h7FFF_FFFF, 1'b1, '{ST_OK,   32'h0000_0000, 7'd0, 7'd1}},
    '{CMD_APPEND,  7'd127, 32'h8000_0000, 1'b1, '{ST_OK,   32'h0000_0000, 7'd0, 7'd2}},
    '{CMD_APPEND,  7'd0,   32'hFFFF_FFFF, 1'b1, '{ST_OK,   32'h0000_0000, 7'd0, 7'd3}},
    '{CMD_APPEND,  7'd0,   32'h0000_0000, 1'b1, '{ST_OK,   32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_FIND,    7'd0,   32'h7FFF_FFFF, 1'b1, '{ST_OK,   32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_FIND,    7'd0,   32'h8000_0000, 1'b1, '{ST_OK,   32'h7FFF_FFFF, 7'd1, 7'd4}},
    '{CMD_FIND,    7'd0,   32'h0001_2345, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_INSERT,  7'd0,   32'h0000_0005, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_INSERT,  7'd4,   32'h55AA_55AA, 1'b0, '0},
    '{CMD_INSERT,  7'd1,   32'hAAAA_5555, 1'b0, '0},
    '{CMD_READ,    7'd6,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,    7'd7,   32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd6}},
    '{CMD_READ,    7'd127, 32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd6}},
    '{CMD_DELETE,  7'd1,   32'h0000_0000, 1'b0, '0},
    '{CMD_DELETE,  7'd5,   32'h0000_0000, 1'b0, '0},
    '{CMD_SPARE_A, 7'd0,   32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_SPARE_B, 7'd1,   32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_SPARE_C, 7'd2,   32'hFFFF_FFFF, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_READ,    7'd0,   32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_DELETE,  7'd0,   32'h0000_0000, 1'b1, '{ST_MISS, 32'h0000_0000, 7'd0, 7'd4}},
    '{CMD_FIND,    7'd0,   32'hFFFF_FFFF, 1'b0, '0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  cmd = '0;
  logic [POS_W-1:0]  position = '0;
  logic [DATA_W-1:0] value_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] value_out;
  logic [POS_W-1:0]  position_out;
  logic [POS_W-1:0]  entry_count;

  logic [DATA_W-1:0] list_vals [LIST_CAP];
  int                list_len = 0;
  list_result_t      pending_results [$];
  int                error_count = 0;
  int                idle_cycles = 0;
  int                burst_left = 0;
  bit                steady_sender = 1'b0;
  bit                growing = 1'b1;
  stall_mode_t       stall_mode = STALL_NONE;
  int                stall_timer = 0;

  ordered_list_store_core #(
    .CAPACITY   (LIST_CAP),
    .VALUE_WIDTH(DATA_W)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .position    (position),
    .value_in    (value_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .value_out   (value_out),
    .position_out(position_out),
    .entry_count (entry_count)
  );

  always #5 clk = ~clk;

  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] op,
                                                      logic [POS_W-1:0] pos,
                                                      logic [DATA_W-1:0] val);
    list_result_t r;
    int p;
    bit pos_ok;
    r = '{ST_OK, '0, '0, '0};
    p = int'(pos);
    pos_ok = (p >= 1) && (p <= list_len);
    case (op)
      CMD_APPEND: begin
        if (list_len >= LIST_CAP) begin
          r.st = ST_FULL;
        end else begin
          list_vals[list_len] = val;
          list_len++;
        end
      end
      CMD_FIND: begin
        r.st = ST_MISS;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == val) begin
            r.st = ST_OK;
            r.pos = POS_W'(i);
            r.value = (i > 0) ? list_vals[i-1] : '0;
            break;
          end
        end
      end
      CMD_INSERT: begin
        if (list_len >= LIST_CAP) begin
          r.st = ST_FULL;
        end else if (!pos_ok) begin
          r.st = ST_MISS;
        end else begin
          for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p] = val;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (!pos_ok) begin
          r.st = ST_MISS;
        end else begin
          for (int i = p - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      CMD_READ: begin
        if (!pos_ok) r.st = ST_MISS;
        else r.value = list_vals[p-1];
      end
      default: r.st = ST_MISS;
    endcase
    r.count = POS_W'(list_len);
    return r;
  endfunction

  // half of the values come from a small pool so that duplicates show up in the list
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0000;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    logic [POS_W-1:0] p;
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = POS_W'(list_len + 1);
      2: p = POS_W'($urandom_range(0, 127));
      default: p = (list_len > 0) ? POS_W'($urandom_range(1, list_len)) : POS_W'(1);
    endcase
    return p;
  endfunction

  task automatic choose_random_command(output logic [CMD_W-1:0] op,
                                       output logic [POS_W-1:0] pos,
                                       output logic [DATA_W-1:0] val);
    int roll;
    if (list_len == 0) growing = 1'b1;
    else if (list_len == LIST_CAP && $urandom_range(0, 7) == 0) growing = 1'b0;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 30) op = CMD_APPEND;
      else if (roll < 55) op = CMD_INSERT;
      else if (roll < 65) op = CMD_DELETE;
      else if (roll < 80) op = CMD_FIND;
      else if (roll < 95) op = CMD_READ;
      else op = CMD_SPARE_A + CMD_W'($urandom_range(0, 2));
    end else begin
      if (roll < 5) op = CMD_APPEND;
      else if (roll < 10) op = CMD_INSERT;
      else if (roll < 55) op = CMD_DELETE;
      else if (roll < 75) op = CMD_FIND;
      else if (roll < 95) op = CMD_READ;
      else op = CMD_SPARE_A + CMD_W'($urandom_range(0, 2));
    end
    pos = pick_position();
    if (op == CMD_FIND && list_len > 0 && $urandom_range(0, 9) < 7)
      val = list_vals[$urandom_range(0, list_len - 1)];
    else
      val = pick_value();
  endtask

  task automatic send_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val, input logic fixed,
                              input list_result_t want);
    list_result_t predicted;
    int gap;
    in_valid <= 1'b1;
    cmd <= op;
    position <= pos;
    value_in <= val;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_command(op, pos, val);
    pending_results.push_back(fixed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = steady_sender ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(100, 500);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_timer[4:0] < 5'd24);
    endcase
  end

  always @(posedge clk) begin : result_check
    list_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $error("result transaction with no command pending");
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", DATA_W'(exp_r.st), DATA_W'(status));
        check_field("value_out", exp_r.value, value_out);
        check_field("position_out", DATA_W'(exp_r.pos), DATA_W'(position_out));
        check_field("entry_count", DATA_W'(exp_r.count), DATA_W'(entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ordered_list_store_core_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    list_cmd_row_t     row;
    logic [CMD_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < N_DIRECTED; k++) begin
      row = DIRECTED_ROWS[k];
      send_command(row.op, row.pos, row.val, row.fixed, row.want);
    end
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 150 == 0) steady_sender = ($urandom_range(0, 3) == 0);
      choose_random_command(op, pos, val);
      send_command(op, pos, val, 1'b0, '0);
      if (k % 400 == 399) drain_results();
    end
    drain_results();
    repeat (LIST_CAP + 8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ordered_list_store_core_tb: clean");
    end else begin
      $display("ordered_list_store_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/olst_pkg.sv
rtl/olst_cell.sv
rtl/ordered_list_store_core.sv
rtl/olst_checker.sv
tb/ordered_list_store_core_tb.sv
